// ===== sv/rotor_command_line_parser_unit_defines.svh =====
// assertion macros shared by the rotor command line parser rtl
`ifndef ROTOR_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH
`define ROTOR_COMMAND_LINE_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i and quiet while rst_ni is low
`define RCLP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rclp assertion failed");

// next-cycle implication, clocked on clk_i and quiet while rst_ni is low
`define RCLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rclp assertion failed");

`endif

// ===== sv/rclp_pkg.sv =====
// types and constants of the rotor command line parser
package rclp_pkg;

  // ascii codes used by the parser and the reply builder
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // only the first twelve line positions are ever examined
  localparam int unsigned STORE_DEPTH = 12;

  // decimal thresholds
  localparam int unsigned DEC_TEN      = 10;
  localparam int unsigned DEC_HUNDRED  = 100;
  localparam int unsigned DEC_THOUSAND = 1000;

  // binary to bcd converter size
  localparam int unsigned BCD_BITS   = 12;
  localparam int unsigned BCD_DIGITS = 4;
  localparam int unsigned BCD_CNT_W  = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CONVERT,
    ST_TARGET,
    ST_EMIT
  } ctrl_state_e;

  // reply template slots, walked in order; slots that do not apply are skipped
  typedef enum logic [4:0] {
    CS_A,
    CS_Z,
    CS_EQ,
    CS_AZ_PAD,
    CS_AZ_D2,
    CS_AZ_D1,
    CS_AZ_D0,
    CS_SP,
    CS_E,
    CS_L,
    CS_EQ2,
    CS_EL_ZERO,
    CS_EL_SIGN,
    CS_EL_D3,
    CS_EL_D2,
    CS_EL_D1,
    CS_EL_D0,
    CS_CR
  } char_sel_e;

  typedef struct packed {
    logic      take;
    logic      latch_target;
    logic      conv_start;
    logic      reply;
    char_sel_e slot;
  } dp_cmd_t;

  typedef struct packed {
    logic rx_cr;
    logic is_target;
    logic is_c;
    logic is_c2;
    logic is_b;
    logic az_ge10;
    logic az_ge100;
    logic el_neg;
    logic el_ge10;
    logic el_ge100;
    logic el_ge1000;
    logic conv_done;
  } dp_status_t;

endpackage

// ===== sv/rclp_in_if.sv =====
// input channel: received byte and measured azimuth
interface rclp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  logic [8:0] current_azimuth;

  modport source (output valid, rx_char, current_azimuth, input ready);
  modport sink (input valid, rx_char, current_azimuth, output ready);
endinterface

// ===== sv/rclp_out_if.sv =====
// output channel: target update or reply character
interface rclp_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] target_azimuth;
  logic signed [12:0] target_elevation;
  logic [7:0]         tx_char;
  logic               last;

  modport source (output valid, kind, target_azimuth, target_elevation, tx_char, last,
                  input ready);
  modport sink (input valid, kind, target_azimuth, target_elevation, tx_char, last,
                output ready);
endinterface

// ===== sv/rclp_bcd_conv.sv =====
// iterative binary to bcd converter, one bit per cycle
module rclp_bcd_conv (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic [rclp_pkg::BCD_BITS-1:0]            bin_i,
  output logic [4*rclp_pkg::BCD_DIGITS-1:0]        bcd_o,
  output logic                                     done_o
);
  import rclp_pkg::*;

  localparam int unsigned BcdW = 4 * BCD_DIGITS;

  logic [BCD_BITS-1:0]  bin_q, bin_d;
  logic [BcdW-1:0]      bcd_q, bcd_d, adj;
  logic [BCD_CNT_W-1:0] cnt_q, cnt_d;

  // add three to every digit of five or more, then shift in the next bit
  always_comb begin
    logic [3:0] nib;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      nib = bcd_q[4*k +: 4];
      adj[4*k +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (start_i) begin
      bin_d = bin_i;
      bcd_d = '0;
      cnt_d = BCD_CNT_W'(BCD_BITS);
    end else if (cnt_q != '0) begin
      bcd_d = {adj[BcdW-2:0], bin_q[BCD_BITS-1]};
      bin_d = {bin_q[BCD_BITS-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // shift registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign bcd_o  = bcd_q;
  assign done_o = (cnt_q == '0);

endmodule

// ===== sv/rclp_datapath.sv =====
// line store, target arithmetic, elevation register and reply character select
module rclp_datapath #(
  parameter int unsigned LINE_LEN = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rclp_pkg::dp_cmd_t    cmd_i,
  output rclp_pkg::dp_status_t status_o,
  input  logic [7:0]           rx_char_i,
  input  logic [8:0]           current_azimuth_i,
  output logic                 kind_o,
  output logic signed [15:0]   target_azimuth_o,
  output logic signed [12:0]   target_elevation_o,
  output logic [7:0]           tx_char_o,
  output logic                 last_o
);
  import rclp_pkg::*;

  localparam int unsigned       IdxW    = $clog2(LINE_LEN);
  localparam logic [IdxW-1:0]   IdxLast = IdxW'(LINE_LEN - 1);
  localparam int unsigned       BcdW    = 4 * BCD_DIGITS;

  logic [7:0]         line_q [STORE_DEPTH];
  logic [IdxW-1:0]    idx_q, idx_d;
  logic signed [12:0] stored_el_q;
  logic signed [15:0] tgt_az_q;
  logic [8:0]         az_q;

  logic               rx_cr;
  logic               is_w;
  logic               use_h;
  logic [7:0]         h_ch, t_ch, u_ch, et_ch, eu_ch;
  logic signed [8:0]  h_d, t_d, u_d, et_d, eu_d;
  logic signed [15:0] h_v, t_v, u_v;
  logic signed [12:0] et_v, eu_v;
  logic signed [15:0] az_calc;
  logic signed [12:0] el_calc;
  logic signed [12:0] el_negated;
  logic [BCD_BITS-1:0] el_mag;
  logic [BcdW-1:0]    az_bcd, el_bcd;
  logic               az_done, el_done;
  logic [7:0]         reply_ch;

  function automatic logic signed [8:0] dig(input logic [7:0] ch);
    dig = $signed({1'b0, ch} - {1'b0, CH_0});
  endfunction

  function automatic logic [7:0] dec_ch(input logic [3:0] nib);
    dec_ch = CH_0 + {4'b0000, nib};
  endfunction

  assign rx_cr = (rx_char_i == CH_CR);

  // write index: saturates at LINE_LEN - 1, back to zero on carriage return
  always_comb begin
    priority if (rx_cr) begin
      idx_d = '0;
    end else if (idx_q != IdxLast) begin
      idx_d = idx_q + 1'b1;
    end else begin
      idx_d = idx_q;
    end
  end

  // line store, index and stored elevation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        line_q[i] <= '0;
      end
      idx_q       <= '0;
      stored_el_q <= '0;
    end else begin
      if (cmd_i.take) begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          if (idx_q == IdxW'(i)) begin
            line_q[i] <= rx_char_i;
          end
        end
        idx_q <= idx_d;
      end
      if (cmd_i.latch_target) begin
        stored_el_q <= el_calc;
      end
    end
  end

  // beat payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      az_q <= current_azimuth_i;
    end
    if (cmd_i.latch_target) begin
      tgt_az_q <= az_calc;
    end
  end

  // digit positions per line form
  assign is_w = (line_q[0] == CH_W);

  always_comb begin
    priority if (is_w) begin
      use_h = 1'b1;
      h_ch  = line_q[1];
      t_ch  = line_q[2];
      u_ch  = line_q[3];
      et_ch = line_q[6];
      eu_ch = line_q[7];
    end else if (line_q[4] != CH_DOT) begin
      use_h = 1'b1;
      h_ch  = line_q[2];
      t_ch  = line_q[3];
      u_ch  = line_q[4];
      et_ch = line_q[10];
      eu_ch = line_q[11];
    end else begin
      use_h = 1'b0;
      h_ch  = line_q[2];
      t_ch  = line_q[2];
      u_ch  = line_q[3];
      et_ch = line_q[9];
      eu_ch = line_q[10];
    end
  end

  // target arithmetic, no digit check
  always_comb begin
    h_d  = dig(h_ch);
    t_d  = dig(t_ch);
    u_d  = dig(u_ch);
    et_d = dig(et_ch);
    eu_d = dig(eu_ch);
    h_v  = use_h ? {{7{h_d[8]}}, h_d} : '0;
    t_v  = {{7{t_d[8]}}, t_d};
    u_v  = {{7{u_d[8]}}, u_d};
    et_v = {{4{et_d[8]}}, et_d};
    eu_v = {{4{eu_d[8]}}, eu_d};
    az_calc = h_v * 16'sd100 + t_v * 16'sd10 + u_v;
    el_calc = et_v * 13'sd10 + eu_v;
  end

  // elevation magnitude for the reply
  assign el_negated = -stored_el_q;
  assign el_mag     = stored_el_q[12] ? el_negated[BCD_BITS-1:0]
                                      : stored_el_q[BCD_BITS-1:0];

  rclp_bcd_conv u_az_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.conv_start),
    .bin_i   ({{(BCD_BITS - 9){1'b0}}, az_q}),
    .bcd_o   (az_bcd),
    .done_o  (az_done)
  );

  rclp_bcd_conv u_el_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.conv_start),
    .bin_i   (el_mag),
    .bcd_o   (el_bcd),
    .done_o  (el_done)
  );

  // status toward the controller
  always_comb begin
    status_o.rx_cr     = rx_cr;
    status_o.is_target = ((line_q[0] == CH_A) && (line_q[1] == CH_Z)) || is_w;
    status_o.is_c      = (line_q[0] == CH_C);
    status_o.is_c2     = (line_q[0] == CH_C) && (line_q[1] == CH_2);
    status_o.is_b      = (line_q[0] == CH_B);
    status_o.az_ge10   = (az_q >= 9'(DEC_TEN));
    status_o.az_ge100  = (az_q >= 9'(DEC_HUNDRED));
    status_o.el_neg    = stored_el_q[12];
    status_o.el_ge10   = (el_mag >= BCD_BITS'(DEC_TEN));
    status_o.el_ge100  = (el_mag >= BCD_BITS'(DEC_HUNDRED));
    status_o.el_ge1000 = (el_mag >= BCD_BITS'(DEC_THOUSAND));
    status_o.conv_done = az_done && el_done;
  end

  // reply character for the current template slot
  always_comb begin
    unique case (cmd_i.slot)
      CS_A:       reply_ch = CH_A;
      CS_Z:       reply_ch = CH_Z;
      CS_EQ:      reply_ch = CH_EQ;
      CS_AZ_PAD:  reply_ch = CH_0;
      CS_AZ_D2:   reply_ch = dec_ch(az_bcd[11:8]);
      CS_AZ_D1:   reply_ch = dec_ch(az_bcd[7:4]);
      CS_AZ_D0:   reply_ch = dec_ch(az_bcd[3:0]);
      CS_SP:      reply_ch = CH_SP;
      CS_E:       reply_ch = CH_E;
      CS_L:       reply_ch = CH_L;
      CS_EQ2:     reply_ch = CH_EQ;
      CS_EL_ZERO: reply_ch = CH_0;
      CS_EL_SIGN: reply_ch = CH_MINUS;
      CS_EL_D3:   reply_ch = dec_ch(el_bcd[15:12]);
      CS_EL_D2:   reply_ch = dec_ch(el_bcd[11:8]);
      CS_EL_D1:   reply_ch = dec_ch(el_bcd[7:4]);
      CS_EL_D0:   reply_ch = dec_ch(el_bcd[3:0]);
      CS_CR:      reply_ch = CH_CR;
      default:    reply_ch = CH_CR;
    endcase
  end

  // output beat payload
  assign kind_o             = cmd_i.reply;
  assign target_azimuth_o   = cmd_i.reply ? '0 : tgt_az_q;
  assign target_elevation_o = cmd_i.reply ? '0 : stored_el_q;
  assign tx_char_o          = cmd_i.reply ? reply_ch : '0;
  assign last_o             = !cmd_i.reply || (cmd_i.slot == CS_CR);

endmodule

// ===== sv/rclp_ctrl.sv =====
// controller: byte intake, line decode, conversion wait and reply sequencing
`include "rotor_command_line_parser_unit_defines.svh"

module rclp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  rclp_pkg::dp_status_t status_i,
  output rclp_pkg::dp_cmd_t    cmd_o
);
  import rclp_pkg::*;

  ctrl_state_e state_q, state_d;
  char_sel_e   slot_q, slot_d;
  logic        slot_on;

  // whether the current slot produces a character for this line
  always_comb begin
    unique case (slot_q)
      CS_AZ_PAD:  slot_on = !status_i.az_ge100;
      CS_AZ_D2:   slot_on = status_i.az_ge100;
      CS_AZ_D1:   slot_on = status_i.az_ge10;
      CS_EL_SIGN: slot_on = status_i.el_neg;
      CS_EL_D3:   slot_on = status_i.el_ge1000;
      CS_EL_D2:   slot_on = status_i.el_ge100;
      CS_EL_D1:   slot_on = status_i.el_ge10;
      default:    slot_on = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.rx_cr) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (status_i.is_target) begin
          state_d = ST_TARGET;
        end else if (status_i.is_c || status_i.is_b) begin
          state_d = ST_CONVERT;
          slot_d  = status_i.is_c ? CS_A : CS_E;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CONVERT: begin
        if (status_i.conv_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_TARGET: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!slot_on || out_ready_i) begin
          priority if (slot_q == CS_CR) begin
            state_d = ST_IDLE;
          end else if (slot_q == CS_AZ_D0) begin
            slot_d = status_i.is_c2 ? CS_SP : CS_CR;
          end else if (slot_q == CS_EL_D0) begin
            slot_d = CS_CR;
          end else begin
            slot_d = char_sel_e'(slot_q + 5'd1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    in_ready_o         = (state_q == ST_IDLE);
    out_valid_o        = (state_q == ST_TARGET) || ((state_q == ST_EMIT) && slot_on);
    cmd_o.take         = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.latch_target = (state_q == ST_DECODE) && status_i.is_target;
    cmd_o.conv_start   = (state_q == ST_DECODE) && !status_i.is_target &&
                         (status_i.is_c || status_i.is_b);
    cmd_o.reply        = (state_q == ST_EMIT);
    cmd_o.slot         = slot_q;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= CS_CR;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  // intake and result beats never overlap
  `RCLP_ASSERT_IMPL(a_no_overlap, in_ready_o, !out_valid_o)
  // a carriage return beat always leads to a line decode
  `RCLP_ASSERT_NEXT(a_cr_decode, in_valid_i && in_ready_o && status_i.rx_cr, state_q == ST_DECODE)
  // replies are only sequenced for C and B lines
  `RCLP_ASSERT_IMPL(a_emit_kind, state_q == ST_EMIT, status_i.is_c || status_i.is_b)
  // a target beat carries the line it was decoded from
  `RCLP_ASSERT_IMPL(a_target_kind, state_q == ST_TARGET, status_i.is_target)

endmodule

// ===== sv/rotor_command_line_parser_unit.sv =====
// Rotor command line parser. Bytes from the receive channel are collected into a line;
// an ordinary byte is taken while the parser is idle and produces nothing. A carriage
// return ends the line: a decode state follows, and an AZ or W line then offers a single
// target update beat, held while the result side stalls, before the input is ready again.
// A C, C2 or B line loads two binary to decimal converters, one for the azimuth and one
// for the elevation, that run side by side; the wait after the load covers 12 shift steps
// (one bit per cycle) and ends when the controller sees them finished. Then the slots of
// an 18-slot reply template are walked, one slot per cycle while the result side does not
// stall: a C2 line walks all 18, a C line stops after the azimuth digits and jumps to the
// carriage return (8 slots), a B line starts at the elevation part (10 slots). A slot that
// does not apply to the values (pad zero, leading digits, sign) offers no beat and is
// passed over; a slot that applies offers one reply character beat and holds while the
// result side stalls. The carriage-return character carries last. No new byte is taken
// until the line's results are all delivered. The line store sits in flip-flops cleared
// at reset, so no clearing pass is needed. LINE_LEN sets where the write index saturates.
module rotor_command_line_parser_unit #(
  parameter int unsigned LINE_LEN = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rclp_in_if.sink           in_i,
  rclp_out_if.source        out_o
);
  import rclp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rclp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rclp_datapath #(
    .LINE_LEN (LINE_LEN)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .rx_char_i          (in_i.rx_char),
    .current_azimuth_i  (in_i.current_azimuth),
    .kind_o             (out_o.kind),
    .target_azimuth_o   (out_o.target_azimuth),
    .target_elevation_o (out_o.target_elevation),
    .tx_char_o          (out_o.tx_char),
    .last_o             (out_o.last)
  );

endmodule
